>>> rtl/lfd_pkg.sv
// Shared types and constants for the Lagrange fractional-delay filter.
package lfd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 20;
    localparam int OFFSET_W   = 16;
    localparam int IDX_W      = 4;
    localparam int FRAC_Q14   = 14;
    localparam int ONE_Q14    = 16384;
    localparam int ACC_MAG_W  = 45;
    localparam int ACC_W      = 46;
    localparam int COEF_SHIFT = 12;
    localparam int COEF_MAX   = 524287;
    localparam int OUT_SHIFT  = 16;
    localparam int OUT_MAX    = 32767;

    localparam logic [63:0] ACC_ONE   = 64'd1 << 28;
    localparam logic [63:0] ACC_LIMIT = 64'd1 << 44;

    typedef enum logic [2:0] {
        CE_IDLE,
        CE_LOAD,
        CE_MUL,
        CE_RND,
        CE_DIV,
        CE_FIX,
        CE_STORE
    } t_ce_state;

    typedef enum logic [1:0] {
        MC_IDLE,
        MC_MAC,
        MC_ACC,
        MC_OUT
    } t_mac_state;

    typedef struct packed {
        logic                     en;
        logic [IDX_W-1:0]         addr;
        logic signed [COEF_W-1:0] data;
    } t_coef_wr;

endpackage

>>> rtl/lfd_coef_engine.sv
// Serial shift-add multiplier and restoring divider that rebuild the coefficient set.
module lfd_coef_engine #(
    parameter int N_POINTS = 5
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic signed [lfd_pkg::OFFSET_W-1:0]     i_offset,
    output logic                                    o_busy,
    output lfd_pkg::t_coef_wr                       o_coef_wr
);

    localparam int H    = N_POINTS / 2;
    localparam int K_W  = $clog2(N_POINTS);
    localparam int T_W  = $clog2((H + 1) * lfd_pkg::ONE_Q14 + 1);
    localparam int TS_W = T_W + 2;
    localparam int M_W  = lfd_pkg::ACC_MAG_W;
    localparam int A_W  = lfd_pkg::ACC_W;
    localparam int P_W  = M_W + T_W;
    localparam int Q_W  = P_W - lfd_pkg::FRAC_Q14;
    localparam int C_W  = $clog2(Q_W);
    localparam int CQ_W = M_W + 1 - lfd_pkg::COEF_SHIFT;

    lfd_pkg::t_ce_state r_state, n_state;

    logic [K_W-1:0]        r_i, n_i;
    logic [K_W-1:0]        r_j, n_j;
    logic [K_W-1:0]        r_k, n_k;
    logic [K_W-1:0]        r_rem, n_rem;
    logic [C_W-1:0]        r_cnt, n_cnt;
    logic signed [A_W-1:0] r_acc, n_acc;
    logic [P_W-1:0]        r_work, n_work;
    logic [M_W-1:0]        r_mcand, n_mcand;
    logic [T_W-1:0]        r_mplier, n_mplier;
    logic                  r_neg, n_neg;

    logic                  last_i, last_j, i_lt_j;
    logic signed [K_W:0]   hj;
    logic signed [TS_W-1:0] t_full;
    logic [TS_W-1:0]       t_abs;
    logic [A_W-1:0]        acc_abs;
    logic [M_W-1:0]        acc_mag;
    logic [P_W-1:0]        rnd_sum;
    logic [K_W:0]          rem_sh;
    logic [K_W:0]          rem_sub;
    logic                  div_ge;
    logic [Q_W-1:0]        q_val;
    logic [Q_W-1:0]        q_cl;
    logic [M_W:0]          c_rnd;
    logic [CQ_W-1:0]       c_q;
    logic signed [lfd_pkg::COEF_W-1:0] coef_sat;

    assign last_i = (r_i == K_W'(N_POINTS - 1));
    assign last_j = (r_j == K_W'(N_POINTS - 1));
    assign i_lt_j = (r_i < r_j);

    // Numerator of one factor: (H - j) in Q14 minus the offset.
    assign hj      = $signed({1'b0, K_W'(H)}) - $signed({1'b0, r_j});
    assign t_full  = (TS_W'(hj) <<< lfd_pkg::FRAC_Q14) - TS_W'(i_offset);
    assign t_abs   = t_full[TS_W-1] ? (-t_full) : t_full;
    assign acc_abs = r_acc[A_W-1] ? (-r_acc) : r_acc;
    assign acc_mag = acc_abs[M_W-1:0];

    // Half of the divisor k * 2^14 is added before the shift, the rest is division by k.
    assign rnd_sum = r_work + (P_W'(r_k) << (lfd_pkg::FRAC_Q14 - 1));
    assign rem_sh  = {r_rem, r_work[Q_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_k});
    assign rem_sub = rem_sh - {1'b0, r_k};

    assign q_val = r_work[Q_W-1:0];
    assign q_cl  = (q_val > Q_W'(lfd_pkg::ACC_LIMIT)) ? Q_W'(lfd_pkg::ACC_LIMIT) : q_val;

    assign c_rnd = {1'b0, acc_mag} + (M_W + 1)'(1 << (lfd_pkg::COEF_SHIFT - 1));
    assign c_q   = c_rnd[M_W:lfd_pkg::COEF_SHIFT];

    always_comb begin
        if (!r_acc[A_W-1]) begin
            if (c_q > CQ_W'(lfd_pkg::COEF_MAX)) begin
                coef_sat = lfd_pkg::COEF_W'(lfd_pkg::COEF_MAX);
            end else begin
                coef_sat = c_q[lfd_pkg::COEF_W-1:0];
            end
        end else begin
            if (c_q > CQ_W'(lfd_pkg::COEF_MAX + 1)) begin
                coef_sat = {1'b1, {(lfd_pkg::COEF_W - 1){1'b0}}};
            end else begin
                coef_sat = -c_q[lfd_pkg::COEF_W-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfd_pkg::CE_IDLE: begin
                if (i_start) n_state = lfd_pkg::CE_LOAD;
            end
            lfd_pkg::CE_LOAD: begin
                if (r_j == r_i) begin
                    if (last_j) n_state = lfd_pkg::CE_STORE;
                end else begin
                    n_state = lfd_pkg::CE_MUL;
                end
            end
            lfd_pkg::CE_MUL: begin
                if (r_cnt == C_W'(T_W - 1)) n_state = lfd_pkg::CE_RND;
            end
            lfd_pkg::CE_RND: n_state = lfd_pkg::CE_DIV;
            lfd_pkg::CE_DIV: begin
                if (r_cnt == C_W'(Q_W - 1)) n_state = lfd_pkg::CE_FIX;
            end
            lfd_pkg::CE_FIX: begin
                n_state = last_j ? lfd_pkg::CE_STORE : lfd_pkg::CE_LOAD;
            end
            lfd_pkg::CE_STORE: begin
                n_state = last_i ? lfd_pkg::CE_IDLE : lfd_pkg::CE_LOAD;
            end
            default: n_state = lfd_pkg::CE_IDLE;
        endcase
    end

    always_comb begin
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_work   = r_work;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_neg    = r_neg;
        unique case (r_state)
            lfd_pkg::CE_IDLE: begin
                if (i_start) begin
                    n_i   = '0;
                    n_j   = '0;
                    n_acc = A_W'(lfd_pkg::ACC_ONE);
                end
            end
            lfd_pkg::CE_LOAD: begin
                if (r_j == r_i) begin
                    if (!last_j) n_j = r_j + 1'b1;
                end else begin
                    n_mcand  = acc_mag;
                    n_mplier = t_abs[T_W-1:0];
                    n_k      = i_lt_j ? (r_j - r_i) : (r_i - r_j);
                    n_neg    = r_acc[A_W-1] ^ t_full[TS_W-1] ^ i_lt_j;
                    n_work   = '0;
                    n_cnt    = '0;
                end
            end
            lfd_pkg::CE_MUL: begin
                n_work   = (r_work << 1) + (r_mplier[T_W-1] ? P_W'(r_mcand) : '0);
                n_mplier = r_mplier << 1;
                n_cnt    = r_cnt + 1'b1;
            end
            lfd_pkg::CE_RND: begin
                n_work = rnd_sum >> lfd_pkg::FRAC_Q14;
                n_rem  = '0;
                n_cnt  = '0;
            end
            lfd_pkg::CE_DIV: begin
                n_rem  = div_ge ? rem_sub[K_W-1:0] : rem_sh[K_W-1:0];
                n_work = {r_work[P_W-1:Q_W], r_work[Q_W-2:0], div_ge};
                n_cnt  = r_cnt + 1'b1;
            end
            lfd_pkg::CE_FIX: begin
                n_acc = r_neg ? (-$signed(A_W'(q_cl))) : $signed(A_W'(q_cl));
                if (!last_j) n_j = r_j + 1'b1;
            end
            lfd_pkg::CE_STORE: begin
                if (!last_i) begin
                    n_i   = r_i + 1'b1;
                    n_j   = '0;
                    n_acc = A_W'(lfd_pkg::ACC_ONE);
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_comb begin
        o_busy         = (r_state != lfd_pkg::CE_IDLE);
        o_coef_wr.en   = (r_state == lfd_pkg::CE_STORE);
        o_coef_wr.addr = lfd_pkg::IDX_W'(r_i);
        o_coef_wr.data = coef_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfd_pkg::CE_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_rem    <= n_rem;
        r_acc    <= n_acc;
        r_work   <= n_work;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_neg    <= n_neg;
    end

endmodule

>>> rtl/lfd_mac.sv
// Delay line, coefficient store and the shared multiply-accumulate with output register.
module lfd_mac #(
    parameter int N_POINTS = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_hold,
    input  lfd_pkg::t_coef_wr                    i_coef_wr,
    output logic                                 o_idle,
    input  logic                                 i_s_valid,
    output logic                                 o_s_ready,
    input  logic [lfd_pkg::SAMPLE_W-1:0]         i_s_data,
    output logic                                 o_m_valid,
    input  logic                                 i_m_ready,
    output logic [lfd_pkg::SAMPLE_W-1:0]         o_m_data,
    output logic                                 o_m_user
);

    localparam int H    = N_POINTS / 2;
    localparam int K_W  = $clog2(N_POINTS);
    localparam int W_W  = $clog2(H + 1);
    localparam int PR_W = lfd_pkg::SAMPLE_W + lfd_pkg::COEF_W;
    localparam int S_W  = PR_W + $clog2(N_POINTS) + 1;
    localparam int OQ_W = S_W + 1 - lfd_pkg::OUT_SHIFT;

    lfd_pkg::t_mac_state r_state, n_state;

    logic signed [lfd_pkg::SAMPLE_W-1:0] r_taps [N_POINTS];
    logic signed [lfd_pkg::COEF_W-1:0]   r_coef [N_POINTS];
    logic [K_W-1:0]                      r_k, n_k;
    logic signed [PR_W-1:0]              r_prod, n_prod;
    logic signed [S_W-1:0]               r_sum, n_sum;
    logic [W_W-1:0]                      r_warm;
    logic                                r_ovalid;
    logic [lfd_pkg::SAMPLE_W-1:0]        r_odata;
    logic                                r_ouser;

    logic                                s_fire;
    logic                                slot_free;
    logic                                out_load;
    logic                                last_k;
    logic [S_W-1:0]                      sum_abs;
    logic [S_W:0]                        y_rnd;
    logic [OQ_W-1:0]                     y_q;
    logic [lfd_pkg::SAMPLE_W-1:0]        y_sat;

    assign s_fire    = i_s_valid && o_s_ready;
    assign slot_free = !r_ovalid || i_m_ready;
    assign last_k    = (r_k == K_W'(N_POINTS - 1));

    // Round half away from zero to Q15, then saturate.
    assign sum_abs = r_sum[S_W-1] ? (-r_sum) : r_sum;
    assign y_rnd   = {1'b0, sum_abs} + (S_W + 1)'(1 << (lfd_pkg::OUT_SHIFT - 1));
    assign y_q     = y_rnd[S_W:lfd_pkg::OUT_SHIFT];

    always_comb begin
        if (!r_sum[S_W-1]) begin
            if (y_q > OQ_W'(lfd_pkg::OUT_MAX)) begin
                y_sat = lfd_pkg::SAMPLE_W'(lfd_pkg::OUT_MAX);
            end else begin
                y_sat = y_q[lfd_pkg::SAMPLE_W-1:0];
            end
        end else begin
            if (y_q > OQ_W'(lfd_pkg::OUT_MAX + 1)) begin
                y_sat = {1'b1, {(lfd_pkg::SAMPLE_W - 1){1'b0}}};
            end else begin
                y_sat = -y_q[lfd_pkg::SAMPLE_W-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfd_pkg::MC_IDLE: begin
                if (s_fire) n_state = lfd_pkg::MC_MAC;
            end
            lfd_pkg::MC_MAC: begin
                if (last_k) n_state = lfd_pkg::MC_ACC;
            end
            lfd_pkg::MC_ACC: n_state = lfd_pkg::MC_OUT;
            lfd_pkg::MC_OUT: begin
                if (slot_free) n_state = lfd_pkg::MC_IDLE;
            end
            default: n_state = lfd_pkg::MC_IDLE;
        endcase
    end

    always_comb begin
        n_k      = r_k;
        n_prod   = r_prod;
        n_sum    = r_sum;
        out_load = 1'b0;
        unique case (r_state)
            lfd_pkg::MC_IDLE: begin
                if (s_fire) begin
                    n_k    = '0;
                    n_prod = '0;
                    n_sum  = '0;
                end
            end
            lfd_pkg::MC_MAC: begin
                // The product of the previous tap is added while the next one is formed.
                n_prod = r_taps[r_k] * r_coef[r_k];
                n_sum  = r_sum + S_W'(r_prod);
                n_k    = r_k + 1'b1;
            end
            lfd_pkg::MC_ACC: begin
                n_sum = r_sum + S_W'(r_prod);
            end
            lfd_pkg::MC_OUT: begin
                out_load = slot_free;
            end
            default: begin
                n_k = '0;
            end
        endcase
    end

    always_comb begin
        o_idle    = (r_state == lfd_pkg::MC_IDLE);
        o_s_ready = (r_state == lfd_pkg::MC_IDLE) && !i_hold;
        o_m_valid = r_ovalid;
        o_m_data  = r_odata;
        o_m_user  = r_ouser;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lfd_pkg::MC_IDLE;
            r_k      <= '0;
            r_warm   <= W_W'(H);
            r_ovalid <= 1'b0;
            for (int n = 0; n < N_POINTS; n++) begin
                r_taps[n] <= '0;
                r_coef[n] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (s_fire) begin
                for (int n = 0; n < N_POINTS - 1; n++) begin
                    r_taps[n] <= r_taps[n + 1];
                end
                r_taps[N_POINTS - 1] <= i_s_data;
            end
            if (i_coef_wr.en) begin
                r_coef[i_coef_wr.addr[K_W-1:0]] <= i_coef_wr.data;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
                if (r_warm != '0) r_warm <= r_warm - 1'b1;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_sum  <= n_sum;
        if (out_load) begin
            r_odata <= y_sat;
            r_ouser <= (r_warm == '0);
        end
    end

endmodule

>>> rtl/lagrange_fractional_delay_core.sv
// Top level of the Lagrange fractional-delay filter: offset register, coefficient engine, MAC.
// Each accepted sample steps through the MAC state once per tap, then the accumulate state and
// the output state, which waits for a free output register; only then is a new sample word
// taken, as the taps share one multiplier. An offset write rebuilds the coefficients serially,
// and no sample or offset word is taken meanwhile. Synchronous active-low reset clears the taps,
// coefficients, offset and warm-up count; the first N_POINTS/2 results carry tuser low.
module lagrange_fractional_delay_core #(
    parameter int N_POINTS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // [15:0] fractional_offset
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] interp_out
    output logic [0:0]  m_axis_tuser    // [0] out_valid
);

    logic signed [lfd_pkg::OFFSET_W-1:0] r_offset;
    logic signed [lfd_pkg::OFFSET_W-1:0] cfg_clamped;
    logic                                cfg_fire;
    logic                                eng_busy;
    logic                                mac_idle;
    logic                                mac_user;
    lfd_pkg::t_coef_wr                   coef_wr;

    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = !eng_busy && mac_idle;

    // Offsets beyond one sample either way are pulled back to the range limit.
    always_comb begin
        if ($signed(i_cfg_data) > $signed(lfd_pkg::OFFSET_W'(lfd_pkg::ONE_Q14))) begin
            cfg_clamped = lfd_pkg::OFFSET_W'(lfd_pkg::ONE_Q14);
        end else if ($signed(i_cfg_data) < -$signed(lfd_pkg::OFFSET_W'(lfd_pkg::ONE_Q14))) begin
            cfg_clamped = -$signed(lfd_pkg::OFFSET_W'(lfd_pkg::ONE_Q14));
        end else begin
            cfg_clamped = $signed(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (cfg_fire) begin
            r_offset <= cfg_clamped;
        end
    end

    lfd_coef_engine #(
        .N_POINTS (N_POINTS)
    ) u_coef_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (cfg_fire),
        .i_offset  (r_offset),
        .o_busy    (eng_busy),
        .o_coef_wr (coef_wr)
    );

    // A pending offset word wins over a sample word in the same cycle.
    lfd_mac #(
        .N_POINTS (N_POINTS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hold    (eng_busy || i_cfg_valid),
        .i_coef_wr (coef_wr),
        .o_idle    (mac_idle),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_s_data  (s_axis_tdata),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_data  (m_axis_tdata),
        .o_m_user  (mac_user)
    );

    assign m_axis_tuser = mac_user;

endmodule

>>> tb/tb_lagrange_fractional_delay_core.sv
// Self-checking testbench for the Lagrange fractional-delay core: offset writes, samples, outputs.
module tb_lagrange_fractional_delay_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NP        = 5;
    localparam int HALF_NP   = NP / 2;
    localparam int DRAIN_GAP = 2 * (NP + 2) + 4;
    localparam int HOLD_LEN  = 400;
    localparam int PHASE_LEN = 75;

    // Idle schemes, in the order the run goes through them.
    localparam logic [1:0] IDLE_SEND_LIGHT = 2'd0;
    localparam logic [1:0] IDLE_RECV_LIGHT = 2'd1;
    localparam logic [1:0] IDLE_NONE       = 2'd2;

    typedef struct packed {
        logic [15:0] interp;
        logic        warm;
    } t_interp_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [15:0] sample_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [15:0] interp_out
    logic [0:0]  m_axis_tuser;          // [0] out_valid

    logic [1:0]  idle_scheme = IDLE_SEND_LIGHT;
    logic        hold_req = 1'b0;
    logic        hold_on = 1'b0;
    int          mismatch_count = 0;

    logic [15:0]        sample_queue[$];
    t_interp_word       interp_expected[$];

    // Predictor state.
    logic signed [15:0] tap_line [NP];
    logic signed [19:0] coef_line [NP];
    int                 warm_left = HALF_NP;

    lagrange_fractional_delay_core #(.N_POINTS(NP)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Division with rounding half away from zero; den is positive.
    function automatic longint div_half_away(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void rebuild_coefs(input logic [15:0] raw);
        longint dx;
        longint acc;
        longint t;
        longint den;
        dx = longint'($signed(raw));
        dx = clip(dx, -lfd_pkg::ONE_Q14, lfd_pkg::ONE_Q14);
        for (int i = 0; i < NP; i++) begin
            acc = longint'(1) << 28;
            for (int j = 0; j < NP; j++) begin
                if (i != j) begin
                    t = longint'(HALF_NP - j) * lfd_pkg::ONE_Q14 - dx;
                    den = longint'(i - j) * lfd_pkg::ONE_Q14;
                    if (den < 0) begin
                        den = -den;
                        t = -t;
                    end
                    acc = div_half_away(acc * t, den);
                    acc = clip(acc, -(longint'(1) << 44), longint'(1) << 44);
                end
            end
            coef_line[i] = 20'(clip(div_half_away(acc, longint'(1) << lfd_pkg::COEF_SHIFT),
                                    -longint'(lfd_pkg::COEF_MAX) - 1, lfd_pkg::COEF_MAX));
        end
    endfunction

    // Shift one sample into the delay line (tap 0 oldest) and queue the filter output.
    function automatic void interpolate_sample(input logic [15:0] sample);
        longint       sum;
        t_interp_word word;
        sum = 0;
        for (int k = 0; k < NP - 1; k++)
            tap_line[k] = tap_line[k + 1];
        tap_line[NP - 1] = $signed(sample);
        for (int k = 0; k < NP; k++)
            sum += longint'(tap_line[k]) * longint'(coef_line[k]);
        word.interp = 16'(clip(div_half_away(sum, longint'(1) << lfd_pkg::OUT_SHIFT),
                               -longint'(lfd_pkg::OUT_MAX) - 1, lfd_pkg::OUT_MAX));
        if (warm_left != 0) begin
            warm_left--;
            word.warm = 1'b0;
        end else begin
            word.warm = 1'b1;
        end
        interp_expected.push_back(word);
    endfunction

    function automatic logic send_idle();
        case (idle_scheme)
            IDLE_SEND_LIGHT: return $urandom_range(99) < 36;
            IDLE_RECV_LIGHT: return $urandom_range(99) < 47;
            default:         return 1'b0;
        endcase
    endfunction

    function automatic logic recv_idle();
        case (idle_scheme)
            IDLE_SEND_LIGHT: return $urandom_range(99) < 47;
            IDLE_RECV_LIGHT: return $urandom_range(99) < 36;
            default:         return 1'b0;
        endcase
    endfunction

    // Sample driver: the prediction is made when the word is taken by the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid)
                interpolate_sample(s_axis_tdata);
            if (sample_queue.size() != 0 && !send_idle()) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= sample_queue.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor.
    always @(posedge i_clk) begin
        t_interp_word want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (interp_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected output word %h", m_axis_tdata));
                end else begin
                    want = interp_expected.pop_front();
                    if (m_axis_tdata !== want.interp)
                        report_mismatch($sformatf("interp_out %h, expected %h",
                                                  m_axis_tdata, want.interp));
                    if (m_axis_tuser[0] !== want.warm)
                        report_mismatch($sformatf("out_valid %b, expected %b",
                                                  m_axis_tuser[0], want.warm));
                end
            end
            m_axis_tready <= !(hold_on || recv_idle());
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    task automatic wait_drained();
        while (sample_queue.size() != 0 || s_axis_tvalid || interp_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_offset(input logic [15:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        rebuild_coefs(value);
    endtask

    function automatic logic [15:0] random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return 16'($urandom);
        else if (pick < 85)
            return $urandom_range(1) ? 16'h7fff : 16'h8000;
        else
            return 16'($signed($urandom_range(63)) - 32);
    endfunction

    initial begin
        logic [15:0] offsets [12];
        for (int k = 0; k < NP; k++) begin
            tap_line[k]  = '0;
            coef_line[k] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Coefficients are still zero after reset; also covers the warm-up words.
        sample_queue.push_back(16'h7fff);
        sample_queue.push_back(16'h8000);
        sample_queue.push_back(16'h0001);
        sample_queue.push_back(16'hffff);
        sample_queue.push_back(16'h5555);

        // Zero offset: a pure delay through the center tap.
        write_offset(16'h0000);
        sample_queue.push_back(16'h7fff);
        sample_queue.push_back(16'h8000);
        sample_queue.push_back(16'h0000);
        sample_queue.push_back(16'haaaa);
        sample_queue.push_back(16'h0001);
        sample_queue.push_back(16'hffff);

        // Half-sample offset: alternating full-scale words, followed by two zero words.
        write_offset(16'h2000);
        for (int k = 0; k < 8; k++)
            sample_queue.push_back((k % 2) ? 16'h8000 : 16'h7fff);
        sample_queue.push_back(16'h0000);
        sample_queue.push_back(16'h0000);

        offsets[0]  = 16'hc000;                        // -1.0
        offsets[1]  = 16'h4000;                        // +1.0
        offsets[2]  = 16'h8000;                        // far below range, saturated
        offsets[3]  = 16'h7fff;                        // far above range, saturated
        offsets[4]  = 16'h4001;
        offsets[5]  = 16'hbfff;
        offsets[6]  = 16'($signed($urandom_range(32768)) - 16384);
        offsets[7]  = 16'($signed($urandom_range(32768)) - 16384);
        offsets[8]  = 16'($urandom);
        offsets[9]  = 16'($signed($urandom_range(32768)) - 16384);
        offsets[10] = 16'h0001;
        offsets[11] = 16'hffff;

        for (int ph = 0; ph < 12; ph++) begin
            write_offset(offsets[ph]);
            idle_scheme <= (ph < 4) ? IDLE_SEND_LIGHT :
                           (ph < 8) ? IDLE_RECV_LIGHT : IDLE_NONE;
            if (ph == 2)
                hold_req <= 1'b1;
            for (int n = 0; n < PHASE_LEN; n++)
                sample_queue.push_back(random_sample());
        end

        wait_drained();
        if (interp_expected.size() != 0)
            report_mismatch($sformatf("%0d output words never arrived",
                                      interp_expected.size()));
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
rtl/lfd_pkg.sv
rtl/lfd_coef_engine.sv
rtl/lfd_mac.sv
rtl/lagrange_fractional_delay_core.sv
tb/tb_lagrange_fractional_delay_core.sv
